// ----- sv/frt_pkg.sv -----
`timescale 1ns / 1ps
package frt_pkg;
    localparam int PENDING_SLOTS_DEF = 8;
    localparam int MAX_FRAGMENTS_DEF = 64;
    localparam int HEADER_BYTES = 14;
    localparam logic [31:0] MAGIC_RESET = 32'h5353_4852;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;
    localparam int MAX_OUT = 8;

    typedef enum logic [1:0] {
        REG_ENABLE  = 2'd0,
        REG_MAGIC   = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_STORED    = 4'd0,
        ST_DUP       = 4'd1,
        ST_COMPLETE  = 4'd2,
        ST_NOT_RX    = 4'd3,
        ST_SHORT     = 4'd4,
        ST_BAD_MAGIC = 4'd5,
        ST_ZERO_TOT  = 4'd6,
        ST_IDX_RANGE = 4'd7,
        ST_BAD_PAY   = 4'd8,
        ST_TOO_MANY  = 4'd9,
        ST_FULL      = 4'd10,
        ST_EXPIRED   = 4'd11,
        ST_SWEEP_NONE = 4'd12,
        ST_RESTART   = 4'd13
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SWEEP,
        S_OUT
    } fsm_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] datagram_length;
        logic [31:0] magic_word;
        logic [31:0] frame_number;
        logic [15:0] fragment_index;
        logic [15:0] fragment_total;
        logic [15:0] payload_bytes;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  slot_index;
        logic [31:0] frame_out;
        logic [15:0] fragment_out;
        logic [15:0] total_out;
        logic [6:0]  received_count;
        logic        last;
    } out_item_t;
endpackage

// ----- sv/frt_if.sv -----
`timescale 1ns / 1ps
interface frt_in_if;
    logic               valid;
    logic               ready;
    frt_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface frt_out_if;
    logic               valid;
    logic               ready;
    frt_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/fragment_reassembly_tracker.sv -----
`timescale 1ns / 1ps
// Fragment reassembly tracker.
// Input channel "in" carries a datagram header (kind 0) or a sweep request
// (kind 1); output channel "out" carries one result per header and one to
// eight results per sweep, the final one marked by last.
// Slot state (frame id, total, first-seen time, bitmap, count) lives in a
// one-port synchronous memory with a registered read; valid bits are
// flip-flops. A header is scanned one slot per cycle for a match, then the
// chosen slot is read, modified and written back.
// A refused header or an early sweep has its result registered from the checks
// made in S_SCAN or S_SWEEP; an accepted header goes through the serial slot
// scan in S_SCAN, then read-modify-write in S_UPDATE. A sweep walks all slots,
// one memory read per cycle while out is free, and holds each eviction until
// the next one is found or the walk ends.
// One item is in flight at a time; in is ready only when idle.
// Reset empties the table at once through the valid bits; no clearing pass.
// A write to receive_enable also empties the table and sweep history.
// When out stalls, the result register holds and the walk waits for it.
module fragment_reassembly_tracker #(
    parameter int PENDING_SLOTS = frt_pkg::PENDING_SLOTS_DEF,
    parameter int MAX_FRAGMENTS = frt_pkg::MAX_FRAGMENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    frt_in_if.sink      in,
    frt_out_if.source   out
);
    import frt_pkg::*;

    localparam int SW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int CW = $clog2(PENDING_SLOTS + 1);

    typedef struct packed {
        logic [31:0] frame;
        logic [6:0]  total;
        logic [31:0] first;
        logic [63:0] bitmap;
        logic [6:0]  count;
    } slot_t;

    slot_t mem [PENDING_SLOTS];
    slot_t rd_reg;
    logic  mem_we;
    logic [SW-1:0] mem_addr;
    slot_t wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= wr_data;
        rd_reg <= mem[mem_addr];
    end

    logic enable_reg;
    logic [31:0] magic_reg;
    logic [15:0] timeout_reg;
    logic [PENDING_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0] last_sweep_reg, last_sweep_next;
    logic swept_reg, swept_next;

    fsm_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] sel_reg, sel_next;
    logic hit_reg, hit_next, free_reg, free_next;
    logic rdv_reg, rdv_next;
    logic [3:0] nev_reg, nev_next;
    logic done_reg, done_next;
    out_item_t res_reg, res_next;
    out_item_t pend_reg, pend_next;
    logic ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            magic_reg   <= MAGIC_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ENABLE:  enable_reg  <= cfg_data[0];
                REG_MAGIC:   magic_reg   <= cfg_data;
                REG_TIMEOUT: timeout_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            last_sweep_reg <= '0;
            swept_reg      <= 1'b0;
            ov_reg         <= 1'b0;
            cnt_reg        <= '0;
            rdv_reg        <= 1'b0;
            nev_reg        <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            last_sweep_reg <= last_sweep_next;
            swept_reg      <= swept_next;
            ov_reg         <= ov_next;
            cnt_reg        <= cnt_next;
            rdv_reg        <= rdv_next;
            nev_reg        <= nev_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        sel_reg  <= sel_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

    assign in.ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out.valid = ov_reg;
    assign out.data  = res_reg;

    logic [SW-1:0] rd_slot_reg;
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= mem_addr;
    end

    logic [16:0] pay_sum;
    logic [31:0] age;
    logic [63:0] bit_mask;
    slot_t cur;
    logic [6:0] new_count;
    logic [6:0] tot7;
    logic out_free;
    logic [CW-1:0] cnt_inc;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        cnt_next        = cnt_reg;
        sel_next        = sel_reg;
        hit_next        = hit_reg;
        free_next       = free_reg;
        rdv_next        = 1'b0;
        nev_next        = nev_reg;
        done_next       = done_reg;
        res_next        = res_reg;
        pend_next       = pend_reg;
        ov_next         = ov_reg;
        valid_next      = valid_reg;
        last_sweep_next = last_sweep_reg;
        swept_next      = swept_reg;
        mem_we          = 1'b0;
        mem_addr        = cnt_reg[SW-1:0];
        wr_data         = rd_reg;
        pay_sum         = 17'(HEADER_BYTES) + {1'b0, item_reg.payload_bytes};
        age             = item_reg.now_ms - rd_reg.first;
        bit_mask        = 64'd1 << item_reg.fragment_index[5:0];
        cur             = rd_reg;
        new_count       = '0;
        tot7            = item_reg.fragment_total[6:0];
        cnt_inc         = cnt_reg + CW'(1);
        out_free        = !ov_reg || out.ready;

        if (ov_reg && out.ready)
            ov_next = 1'b0;

        if (cfg_we && reg_idx_t'(cfg_index) == REG_ENABLE)
        begin
            valid_next      = '0;
            last_sweep_next = '0;
            swept_next      = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in.valid && in.ready)
                begin
                    item_next = in.data;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    nev_next  = '0;
                    done_next = 1'b0;
                    state_next = in.data.kind ? S_SWEEP : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // checks first, then one memory read per slot
                res_next = '{status: ST_STORED, slot_index: '0,
                             frame_out: item_reg.frame_number,
                             fragment_out: item_reg.fragment_index,
                             total_out: item_reg.fragment_total,
                             received_count: '0, last: 1'b1};
                if (!enable_reg || item_reg.datagram_length < 16'(HEADER_BYTES))
                begin
                    res_next.status = enable_reg ? ST_SHORT : ST_NOT_RX;
                    res_next.frame_out = '0;
                    res_next.fragment_out = '0;
                    res_next.total_out = '0;
                    ov_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (item_reg.magic_word != magic_reg)
                begin
                    res_next.status = ST_BAD_MAGIC; ov_next = 1'b1; state_next = S_OUT;
                end
                else if (item_reg.fragment_total == '0)
                begin
                    res_next.status = ST_ZERO_TOT; ov_next = 1'b1; state_next = S_OUT;
                end
                else if (item_reg.fragment_index >= item_reg.fragment_total)
                begin
                    res_next.status = ST_IDX_RANGE; ov_next = 1'b1; state_next = S_OUT;
                end
                else if (item_reg.payload_bytes == '0 ||
                         pay_sum > {1'b0, item_reg.datagram_length})
                begin
                    res_next.status = ST_BAD_PAY; ov_next = 1'b1; state_next = S_OUT;
                end
                else if (item_reg.fragment_total > 16'(MAX_FRAGMENTS))
                begin
                    res_next.status = ST_TOO_MANY; ov_next = 1'b1; state_next = S_OUT;
                end
                else
                begin
                    res_next = res_reg;
                    // evaluate previous read, issue next
                    if (rdv_reg && !hit_reg && valid_reg[rd_slot_reg] &&
                        rd_reg.frame == item_reg.frame_number)
                    begin
                        hit_next = 1'b1;
                        sel_next = rd_slot_reg;
                    end
                    if (!hit_reg && !hit_next && cnt_reg < CW'(PENDING_SLOTS))
                    begin
                        if (!free_reg && !valid_reg[cnt_reg[SW-1:0]])
                        begin
                            free_next = 1'b1;
                            sel_next  = cnt_reg[SW-1:0];
                        end
                        mem_addr = cnt_reg[SW-1:0];
                        rdv_next = 1'b1;
                        cnt_next = cnt_inc;
                    end
                    else if (!rdv_reg || hit_next || hit_reg)
                    begin
                        if (hit_next || hit_reg || free_reg)
                        begin
                            mem_addr   = sel_next;
                            state_next = S_UPDATE;
                            done_next  = 1'b0;
                        end
                        else
                        begin
                            res_next = '{status: ST_FULL, slot_index: '0,
                                         frame_out: item_reg.frame_number,
                                         fragment_out: item_reg.fragment_index,
                                         total_out: item_reg.fragment_total,
                                         received_count: '0, last: 1'b1};
                            ov_next = 1'b1;
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_UPDATE:
            begin
                // rd_reg holds the chosen slot read in the cycle before
                mem_addr = sel_reg;
                if (!done_reg)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    res_next = '{status: ST_STORED,
                                 slot_index: 3'(sel_reg),
                                 frame_out: item_reg.frame_number,
                                 fragment_out: item_reg.fragment_index,
                                 total_out: item_reg.fragment_total,
                                 received_count: '0, last: 1'b1};
                    if (!hit_reg)
                    begin
                        cur = '{frame: item_reg.frame_number, total: tot7,
                                first: item_reg.now_ms, bitmap: '0, count: '0};
                    end
                    else if (rd_reg.total != tot7)
                    begin
                        cur.total = tot7;
                        cur.first = item_reg.now_ms;
                        cur.bitmap = '0;
                        cur.count = '0;
                        res_next.status = ST_RESTART;
                    end
                    if ((cur.bitmap & bit_mask) != '0)
                    begin
                        res_next.status = ST_DUP;
                        res_next.received_count = cur.count;
                    end
                    else
                    begin
                        new_count = cur.count + 7'd1;
                        cur.bitmap = cur.bitmap | bit_mask;
                        cur.count = new_count;
                        res_next.received_count = new_count;
                        valid_next[sel_reg] = 1'b1;
                        if (new_count == cur.total)
                        begin
                            res_next.status = ST_COMPLETE;
                            valid_next[sel_reg] = 1'b0;
                        end
                        wr_data = cur;
                        mem_we  = 1'b1;
                    end
                    ov_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_SWEEP:
            begin
                res_next = '{status: ST_SWEEP_NONE, slot_index: '0, frame_out: '0,
                             fragment_out: '0, total_out: '0,
                             received_count: '0, last: 1'b1};
                if (!enable_reg)
                begin
                    res_next.status = ST_NOT_RX; ov_next = 1'b1; state_next = S_OUT;
                end
                else if (!done_reg && swept_reg &&
                         (item_reg.now_ms - last_sweep_reg) <= {16'd0, timeout_reg})
                begin
                    ov_next = 1'b1; state_next = S_OUT;
                end
                else if (out_free)
                begin
                    if (!done_reg)
                    begin
                        done_next = 1'b1;
                        last_sweep_next = item_reg.now_ms;
                        swept_next = 1'b1;
                    end
                    res_next = res_reg;
                    if (rdv_reg && valid_reg[rd_slot_reg] &&
                        age > {16'd0, timeout_reg} && nev_reg < 4'(MAX_OUT))
                    begin
                        // hold this eviction until the next one or the walk end
                        if (nev_reg != '0)
                        begin
                            res_next = pend_reg;
                            ov_next = 1'b1;
                        end
                        pend_next = '{status: ST_EXPIRED, slot_index: 3'(rd_slot_reg),
                                      frame_out: rd_reg.frame, fragment_out: '0,
                                      total_out: {9'd0, rd_reg.total},
                                      received_count: rd_reg.count, last: 1'b0};
                        nev_next = nev_reg + 4'd1;
                        valid_next[rd_slot_reg] = 1'b0;
                    end
                    if (cnt_reg < CW'(PENDING_SLOTS))
                    begin
                        mem_addr = cnt_reg[SW-1:0];
                        rdv_next = 1'b1;
                        cnt_next = cnt_inc;
                    end
                    else if (!rdv_reg)
                    begin
                        // walk over: close out with a last marker
                        res_next = '{status: ST_SWEEP_NONE, slot_index: '0,
                                     frame_out: '0, fragment_out: '0,
                                     total_out: '0, received_count: '0,
                                     last: 1'b1};
                        if (nev_reg != '0)
                        begin
                            res_next = pend_reg;
                            res_next.last = 1'b1;
                        end
                        ov_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    res_next = res_reg;
                    // hold the pending read by re-reading same slot
                    if (rdv_reg)
                    begin
                        mem_addr = rd_slot_reg;
                        rdv_next = 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |=> out.valid && $stable(out.data))
        else $error("result dropped under stall");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in.valid && in.ready) |=> !in.ready)
        else $error("second item taken while busy");
endmodule

// ----- tb/tb_fragment_reassembly_tracker.sv -----
`timescale 1ns / 1ps
module tb_fragment_reassembly_tracker;
    import frt_pkg::*;

    localparam int NSLOT = 8;
    localparam int MAXFRAG = 64;
    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    frt_in_if in_ch ();
    frt_out_if out_ch ();

    fragment_reassembly_tracker dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in(in_ch.sink),
        .out(out_ch.source)
    );

    // tracker state as predicted
    logic        rx_en;
    logic [31:0] magic_reg;
    logic [15:0] timeout_reg;
    logic        tbl_valid [NSLOT];
    logic [31:0] tbl_frame [NSLOT];
    logic [15:0] tbl_total [NSLOT];
    logic [31:0] tbl_first [NSLOT];
    logic [63:0] tbl_map [NSLOT];
    logic [6:0]  tbl_count [NSLOT];
    logic [31:0] last_sweep;
    logic        swept;

    out_item_t pending_results[$];
    int errors;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    logic [31:0] clock_ms;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic out_item_t mk(status_t st, int slot, logic [31:0] fr,
                                     logic [15:0] fg, logic [15:0] tot,
                                     logic [6:0] cnt);
        out_item_t r;
        r.status = st;
        r.slot_index = slot[2:0];
        r.frame_out = fr;
        r.fragment_out = fg;
        r.total_out = tot;
        r.received_count = cnt;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic empty_table();
        for (int s = 0; s < NSLOT; s++)
        begin
            tbl_valid[s] = 0;
            tbl_frame[s] = 0;
            tbl_total[s] = 0;
            tbl_first[s] = 0;
            tbl_map[s] = 0;
            tbl_count[s] = 0;
        end
        last_sweep = 0;
        swept = 0;
    endtask

    task automatic predict_header(in_item_t it);
        status_t code;
        int hit;
        int freeslot;
        logic restarted;
        logic [63:0] bitv;
        hit = -1;
        freeslot = -1;
        restarted = 0;
        if (!rx_en)
        begin
            pending_results.push_back(mk(ST_NOT_RX, 0, 0, 0, 0, 0));
            return;
        end
        if (it.datagram_length < HEADER_BYTES)
        begin
            pending_results.push_back(mk(ST_SHORT, 0, 0, 0, 0, 0));
            return;
        end
        code = ST_STORED;
        if (it.magic_word != magic_reg) code = ST_BAD_MAGIC;
        else if (it.fragment_total == 0) code = ST_ZERO_TOT;
        else if (it.fragment_index >= it.fragment_total) code = ST_IDX_RANGE;
        else if (it.payload_bytes == 0
                 || 17'(HEADER_BYTES) + 17'(it.payload_bytes) > 17'(it.datagram_length))
            code = ST_BAD_PAY;
        else if (it.fragment_total > MAXFRAG) code = ST_TOO_MANY;
        if (code != ST_STORED)
        begin
            pending_results.push_back(mk(code, 0, it.frame_number, it.fragment_index,
                                         it.fragment_total, 0));
            return;
        end
        for (int s = 0; s < NSLOT; s++)
        begin
            if (tbl_valid[s] && tbl_frame[s] == it.frame_number)
            begin
                hit = s;
                break;
            end
            if (!tbl_valid[s] && freeslot < 0) freeslot = s;
        end
        if (hit < 0)
        begin
            if (freeslot < 0)
            begin
                pending_results.push_back(mk(ST_FULL, 0, it.frame_number,
                    it.fragment_index, it.fragment_total, 0));
                return;
            end
            hit = freeslot;
            tbl_valid[hit] = 1;
            tbl_frame[hit] = it.frame_number;
            tbl_total[hit] = it.fragment_total;
            tbl_first[hit] = it.now_ms;
            tbl_map[hit] = 0;
            tbl_count[hit] = 0;
        end
        else if (tbl_total[hit] != it.fragment_total)
        begin
            tbl_total[hit] = it.fragment_total;
            tbl_first[hit] = it.now_ms;
            tbl_map[hit] = 0;
            tbl_count[hit] = 0;
            restarted = 1;
        end
        bitv = 64'd1 << it.fragment_index[5:0];
        if (tbl_map[hit] & bitv)
        begin
            pending_results.push_back(mk(ST_DUP, hit, it.frame_number, it.fragment_index,
                                         it.fragment_total, tbl_count[hit]));
            return;
        end
        tbl_map[hit] |= bitv;
        tbl_count[hit]++;
        if (16'(tbl_count[hit]) == tbl_total[hit])
        begin
            pending_results.push_back(mk(ST_COMPLETE, hit, it.frame_number,
                it.fragment_index, it.fragment_total, tbl_count[hit]));
            tbl_valid[hit] = 0;
            tbl_map[hit] = 0;
            tbl_count[hit] = 0;
            return;
        end
        pending_results.push_back(mk(restarted ? ST_RESTART : ST_STORED, hit,
            it.frame_number, it.fragment_index, it.fragment_total, tbl_count[hit]));
    endtask

    task automatic predict_sweep(logic [31:0] now);
        int n;
        out_item_t r;
        n = 0;
        if (!rx_en)
        begin
            pending_results.push_back(mk(ST_NOT_RX, 0, 0, 0, 0, 0));
            return;
        end
        if (swept && (now - last_sweep) <= {16'd0, timeout_reg})
        begin
            pending_results.push_back(mk(ST_SWEEP_NONE, 0, 0, 0, 0, 0));
            return;
        end
        last_sweep = now;
        swept = 1;
        for (int s = 0; s < NSLOT && n < MAX_OUT; s++)
        begin
            if (tbl_valid[s] && (now - tbl_first[s]) > {16'd0, timeout_reg})
            begin
                r = mk(ST_EXPIRED, s, tbl_frame[s], 0, tbl_total[s], tbl_count[s]);
                r.last = 0;
                pending_results.push_back(r);
                n++;
                tbl_valid[s] = 0;
                tbl_map[s] = 0;
                tbl_count[s] = 0;
            end
        end
        if (n == 0) pending_results.push_back(mk(ST_SWEEP_NONE, 0, 0, 0, 0, 0));
        else pending_results[$].last = 1;
    endtask

    // receiver: random stall and compare
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_ch.data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want !== out_ch.data)
                begin
                    $display("%0t mismatch expected %h actual %h", $time, want, out_ch.data);
                    errors++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        in_ch.valid <= 1'b0;
        if (it.kind) predict_sweep(it.now_ms);
        else predict_header(it);
        // the block is busy in the cycle after a transfer
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE:
            begin
                rx_en = val[0];
                empty_table();
            end
            REG_MAGIC: magic_reg = val;
            default: timeout_reg = val[15:0];
        endcase
    endtask

    function automatic in_item_t hdr(logic [31:0] fr, int idx, int tot,
                                     logic [31:0] now);
        in_item_t it;
        it.kind = 0;
        it.payload_bytes = 16'($urandom_range(1, 1400));
        it.datagram_length = it.payload_bytes + 16'($urandom_range(14, 40));
        it.magic_word = magic_reg;
        it.frame_number = fr;
        it.fragment_index = 16'(idx);
        it.fragment_total = 16'(tot);
        it.now_ms = now;
        return it;
    endfunction

    function automatic in_item_t sweep_at(logic [31:0] now);
        in_item_t it;
        it = in_item_t'({1'b0, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.kind = 1;
        it.now_ms = now;
        return it;
    endfunction

    task automatic test_disabled();
        send(hdr(32'd1, 0, 2, 0));
        send(sweep_at(32'd1000));
    endtask

    task automatic test_refusals();
        in_item_t it;
        write_reg(REG_ENABLE, 32'd1);
        it = hdr(32'hFFFF_FFFF, 0, 1, 0);
        it.datagram_length = 13;
        send(it);
        it = hdr(32'd2, 0, 1, 0);
        it.magic_word = ~magic_reg;
        send(it);
        send(hdr(32'd3, 0, 0, 0));
        send(hdr(32'd4, 5, 5, 0));
        it = hdr(32'd5, 0, 3, 0);
        it.payload_bytes = 0;
        send(it);
        it = hdr(32'd5, 0, 3, 0);
        it.datagram_length = 16'hFFFF;
        it.payload_bytes = 16'hFFF2;
        send(it);
        it.payload_bytes = 16'hFFF1;
        it.fragment_index = 16'hFFFE;
        it.fragment_total = 16'hFFFF;
        send(it);
        send(hdr(32'd6, 64, 65, 0));
    endtask

    task automatic test_assembly();
        send(hdr(32'hFFFF_FFFF, 0, 1, 0));
        send(hdr(32'd10, 63, 64, 5));
        send(hdr(32'd10, 63, 64, 6));
        send(hdr(32'd11, 0, 3, 7));
        send(hdr(32'd11, 1, 2, 8));
        send(hdr(32'd11, 0, 2, 9));
        send(hdr(32'd12, 0, 2, 9));
        send(hdr(32'd13, 1, 2, 9));
        for (int f = 20; f < 27; f++) send(hdr(f, 0, 4, 10));
        send(hdr(32'd40, 0, 2, 11));
        write_reg(REG_TIMEOUT, 32'd1);
        send(sweep_at(32'hFFFF_FFFF));
        send(sweep_at(32'hFFFF_FFFF));
        write_reg(REG_TIMEOUT, 32'hFFFF);
        write_reg(REG_MAGIC, 32'hFFFF_FFFF);
        send(hdr(32'd50, 0, 2, 0));
        write_reg(REG_MAGIC, 32'h0);
        send(hdr(32'd50, 0, 2, 0));
        write_reg(REG_ENABLE, 32'd0);
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_MAGIC, MAGIC_RESET);
        write_reg(REG_TIMEOUT, 32'd500);
    endtask

    // mostly well-formed frames on a small id set, with noise
    task automatic test_random(int count);
        in_item_t it;
        int r;
        for (int i = 0; i < count; i++)
        begin
            clock_ms += $urandom_range(0, 120);
            r = $urandom_range(99);
            if (r < 70)
            begin
                it = hdr($urandom_range(0, 11), 0, $urandom_range(1, 6), clock_ms);
                it.fragment_index = 16'($urandom_range(0, it.fragment_total - 1));
                if ($urandom_range(9) == 0)
                begin
                    it.fragment_total = 16'($urandom_range(1, 64));
                    it.fragment_index = 16'($urandom_range(0, it.fragment_total - 1));
                end
            end
            else if (r < 85)
                it = sweep_at(clock_ms);
            else
            begin
                it = in_item_t'({1'b0, $urandom, $urandom, $urandom, $urandom, $urandom});
                it.kind = 0;
                if ($urandom_range(1)) it.magic_word = magic_reg;
                if ($urandom_range(1)) it.fragment_total = 16'($urandom_range(0, 70));
                it.now_ms = clock_ms;
            end
            send(it);
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_ENABLE;
        cfg_data = 0;
        in_ch.valid = 0;
        in_ch.data = '0;
        out_ch.ready = 0;
        errors = 0;
        cycles = 0;
        clock_ms = 32'hFFFF_F000;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_en = 0;
        magic_reg = MAGIC_RESET;
        timeout_reg = TIMEOUT_RESET;
        empty_table();
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_disabled();
        test_refusals();
        test_assembly();
        send_idle_pct = 21;
        recv_idle_pct = 51;
        test_random(25);
        write_reg(REG_TIMEOUT, 32'd40);
        send_idle_pct = 51;
        recv_idle_pct = 21;
        test_random(25);
        write_reg(REG_TIMEOUT, 32'd200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(25);
        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/frt_pkg.sv
sv/frt_if.sv
sv/fragment_reassembly_tracker.sv
tb/tb_fragment_reassembly_tracker.sv
